### rtl/assert_macros.svh
// Assertion macros used by the checker module of the cache model.
// No dependencies; include this file by its bare name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHK_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("cache port check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CHK_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("cache port check failed");

`endif

### rtl/lru_sac_pkg.sv
// Types and constants of the LRU set-associative cache model.
// No dependencies; used by the top level and its port checker.
`default_nettype none

package lru_sac_pkg;

	// Default geometry limits.
	localparam int DEF_MAX_SET_BITS = 6;
	localparam int DEF_MAX_WAYS     = 8;
	localparam int DEF_ADDR_WIDTH   = 64;

	// Fixed field widths.
	localparam int ACTION_W    = 2;
	localparam int ADDRESS_W   = 64;
	localparam int OUTCOME_W   = 2;
	localparam int CNT_W       = 32;
	localparam int SET_BITS_W  = 3;
	localparam int BLOCK_BITS_W = 5;
	localparam int WAYS_W      = 4;
	localparam int CFG_DATA_W  = 5;
	localparam int CFG_IDX_W   = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SET_BITS   = 2'd0,
		CFG_BLOCK_BITS = 2'd1,
		CFG_WAYS       = 2'd2
	} cfg_reg_e;

	typedef enum logic [ACTION_W-1:0] {
		ACT_LOAD   = 2'd0,
		ACT_STORE  = 2'd1,
		ACT_MODIFY = 2'd2,
		ACT_FETCH  = 2'd3
	} action_e;

	typedef enum logic [OUTCOME_W-1:0] {
		OUT_IGNORED = 2'd0,
		OUT_HIT     = 2'd1,
		OUT_MISS    = 2'd2,
		OUT_EVICT   = 2'd3
	} outcome_e;

	typedef struct packed {
		logic [ACTION_W-1:0]  action;
		logic [ADDRESS_W-1:0] address;
	} access_t;

	typedef struct packed {
		logic [OUTCOME_W-1:0] outcome;
		logic [CNT_W-1:0]     hits_total;
		logic [CNT_W-1:0]     misses_total;
		logic [CNT_W-1:0]     evictions_total;
	} result_t;

endpackage

`default_nettype wire

### rtl/lru_set_associative_cache_sim.sv
// Top level of the tag-only set-associative cache model with LRU replacement.
// Depends on lru_sac_pkg; checked by lru_sac_chk through a bind.
`default_nettype none

// Channel      Ports                          Transfer
// -----------  -----------------------------  ----------------------------------
// access in    start, busy, cmd               edge with start high and busy low
// result out   done, result                   every edge that ends a cycle with done high
// config       cfg_we, cfg_idx, cfg_wdata     every edge with cfg_we high
//
// An instruction fetch is answered in the cycle after its transfer. Any other
// access passes through the split, scan and update states before the next possible
// transfer; in the scan the tag compare unit visits 1 to MAX_WAYS ways, one way per
// cycle, stopping at the first hit or at the last filled way. The result is strobed
// on done in the cycle after the update, while busy is low. Reset clears the set and
// block bits, the counters and the per-set fill valid bits and sets the way count to
// one at once; there is no clearing pass. The receiver of results cannot stall.

module lru_set_associative_cache_sim
	import lru_sac_pkg::*;
#(
	parameter int MAX_SET_BITS = DEF_MAX_SET_BITS,
	parameter int MAX_WAYS     = DEF_MAX_WAYS,
	parameter int ADDR_WIDTH   = DEF_ADDR_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  access_t               cmd,
	output logic                  done,
	output result_t               result,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	// Storage geometry. A set address and a way number concatenate into the
	// tag memory address, so both are rounded up to whole bits.
	localparam int SET_W     = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
	localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
	localparam int RANK_W    = WAY_W;
	localparam int FILL_W    = $clog2(MAX_WAYS + 1);
	localparam int NUM_SETS  = 1 << SET_W;
	localparam int MEM_W     = SET_W + WAY_W;
	localparam int MEM_DEPTH = 1 << MEM_W;

	typedef logic [MAX_WAYS-1:0][RANK_W-1:0] rank_row_t;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SPLIT  = 4'b0010,
		ST_SCAN   = 4'b0100,
		ST_UPDATE = 4'b1000
	} state_t;

	function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
		input logic [1:0] b);
		logic [CNT_W:0] sum;
		sum = {1'b0, a} + (CNT_W + 1)'(b);
		return sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
	endfunction

	// Configuration registers.
	logic [SET_BITS_W-1:0]   set_bits_q;
	logic [BLOCK_BITS_W-1:0] block_bits_q;
	logic [WAYS_W-1:0]       ways_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_bits_q   <= '0;
			block_bits_q <= '0;
			ways_q       <= WAYS_W'(1);
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_SET_BITS:   set_bits_q   <= cfg_wdata[SET_BITS_W-1:0];
				CFG_BLOCK_BITS: block_bits_q <= cfg_wdata[BLOCK_BITS_W-1:0];
				CFG_WAYS:       ways_q       <= cfg_wdata[WAYS_W-1:0];
				default: ;
			endcase
		end
	end

	// Control and working registers.
	state_t                state_q;
	logic [ACTION_W-1:0]   act_q;
	logic [ADDRESS_W-1:0]  addr_q;
	logic [SET_W-1:0]      set_q;
	logic [ADDR_WIDTH-1:0] tag_q;
	logic [WAY_W-1:0]      way_q;
	logic                  hit_q;
	logic [WAY_W-1:0]      hit_way_q;
	logic [RANK_W-1:0]     hit_rank_q;
	logic [WAY_W-1:0]      victim_q;
	logic [RANK_W-1:0]     victim_rank_q;
	logic [CNT_W-1:0]      hits_q;
	logic [CNT_W-1:0]      misses_q;
	logic [CNT_W-1:0]      evicts_q;
	logic                  done_q;
	result_t               result_q;

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = result_q;

	// Address split: drop the block offset, then take the set index from the
	// low bits of the line number; everything above is the tag, kept in full.
	logic [ADDR_WIDTH-1:0] line;
	logic [SET_BITS_W-1:0] sb;
	logic [SET_W-1:0]      set_n;
	logic [ADDR_WIDTH-1:0] tag_n;

	always_comb begin
		line  = addr_q[ADDR_WIDTH-1:0] >> block_bits_q;
		sb    = (int'(set_bits_q) > MAX_SET_BITS) ? SET_BITS_W'(MAX_SET_BITS) : set_bits_q;
		set_n = line[SET_W-1:0] & ~({SET_W{1'b1}} << sb);
		tag_n = line >> sb;
	end

	// Tag memory, one way per entry, addressed by {set, way}.
	logic [ADDR_WIDTH-1:0] tag_mem [MEM_DEPTH];
	logic [ADDR_WIDTH-1:0] tag_rd_q;
	logic                  tag_re;
	logic                  tag_we;
	logic [MEM_W-1:0]      tag_raddr;
	logic [MEM_W-1:0]      tag_waddr;

	always_ff @(posedge clk) begin
		if (tag_we)
			tag_mem[tag_waddr] <= tag_q;
		if (tag_re)
			tag_rd_q <= tag_mem[tag_raddr];
	end

	// Recency memory, one row of ranks per set; rank zero is the most recent.
	rank_row_t rank_mem [NUM_SETS];
	rank_row_t rank_rd_q;
	rank_row_t rank_wr;
	logic      rank_we;

	always_ff @(posedge clk) begin
		if (rank_we)
			rank_mem[set_q] <= rank_wr;
		if (state_q == ST_SPLIT)
			rank_rd_q <= rank_mem[set_n];
	end

	// Fill counts per set. A set whose valid bit is clear holds no lines.
	logic [FILL_W-1:0]   fill_mem [NUM_SETS];
	logic [FILL_W-1:0]   fill_rd_q;
	logic [NUM_SETS-1:0] fill_vld_q;
	logic [FILL_W-1:0]   fill_cur;
	logic                fill_we;

	always_ff @(posedge clk) begin
		if (fill_we)
			fill_mem[set_q] <= fill_cur + FILL_W'(1);
		if (state_q == ST_SPLIT)
			fill_rd_q <= fill_mem[set_n];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			fill_vld_q <= '0;
		else if (fill_we)
			fill_vld_q[set_q] <= 1'b1;
	end

	assign fill_cur = fill_vld_q[set_q] ? fill_rd_q : '0;

	// Scan: the tag of way way_q arrives from memory while the read of the
	// next way is issued, so the compare unit sees one way each cycle.
	logic [FILL_W-1:0] way_ext;
	logic              way_in_fill;
	logic              last_way;
	logic              tag_match;
	logic [RANK_W-1:0] cur_rank;

	always_comb begin
		way_ext     = FILL_W'(way_q);
		way_in_fill = way_ext < fill_cur;
		last_way    = (way_ext + FILL_W'(1)) >= fill_cur;
		tag_match   = way_in_fill && (tag_rd_q == tag_q);
		cur_rank    = rank_rd_q[way_q];
	end

	assign tag_re    = (state_q == ST_SPLIT) || (state_q == ST_SCAN);
	assign tag_raddr = (state_q == ST_SPLIT) ? {set_n, WAY_W'(0)}
	                                         : {set_q, way_q + WAY_W'(1)};

	// Update: effective way limit, recency row, tag and fill writes, counters.
	logic [FILL_W-1:0]    eff_ways;
	logic                 no_evict;
	logic                 is_modify;
	logic [OUTCOME_W-1:0] outcome_n;
	logic [CNT_W-1:0]     hits_n;
	logic [CNT_W-1:0]     misses_n;
	logic [CNT_W-1:0]     evicts_n;

	always_comb begin
		if (ways_q == '0)
			eff_ways = FILL_W'(1);
		else if (int'(ways_q) > MAX_WAYS)
			eff_ways = FILL_W'(MAX_WAYS);
		else
			eff_ways = FILL_W'(ways_q);
		no_evict  = fill_cur < eff_ways;
		is_modify = (act_q == ACT_MODIFY);

		// On a hit, lines more recent than the hit line age by one; on a miss
		// every filled line ages and the new line becomes rank zero.
		for (int i = 0; i < MAX_WAYS; i++) begin
			rank_wr[i] = rank_rd_q[i];
			if (hit_q) begin
				if (i == int'(hit_way_q))
					rank_wr[i] = '0;
				else if (i < int'(fill_cur) && rank_rd_q[i] < hit_rank_q)
					rank_wr[i] = rank_rd_q[i] + RANK_W'(1);
			end else begin
				if (no_evict && i == int'(fill_cur))
					rank_wr[i] = '0;
				else if (!no_evict && i == int'(victim_q))
					rank_wr[i] = '0;
				else if (i < int'(fill_cur))
					rank_wr[i] = rank_rd_q[i] + RANK_W'(1);
			end
		end

		if (hit_q)
			outcome_n = OUT_HIT;
		else if (no_evict)
			outcome_n = OUT_MISS;
		else
			outcome_n = OUT_EVICT;

		if (hit_q) begin
			hits_n   = sat_add(hits_q, is_modify ? 2'd2 : 2'd1);
			misses_n = misses_q;
		end else begin
			hits_n   = is_modify ? sat_add(hits_q, 2'd1) : hits_q;
			misses_n = sat_add(misses_q, 2'd1);
		end
		evicts_n = (outcome_n == OUT_EVICT) ? sat_add(evicts_q, 2'd1) : evicts_q;
	end

	assign rank_we   = (state_q == ST_UPDATE);
	assign tag_we    = (state_q == ST_UPDATE) && !hit_q;
	assign fill_we   = (state_q == ST_UPDATE) && !hit_q && no_evict;
	assign tag_waddr = {set_q, no_evict ? fill_cur[WAY_W-1:0] : victim_q};

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			way_q    <= '0;
			hit_q    <= 1'b0;
			hits_q   <= '0;
			misses_q <= '0;
			evicts_q <= '0;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						if (cmd.action == ACT_FETCH)
							done_q <= 1'b1;
						else
							state_q <= ST_SPLIT;
					end
				end
				ST_SPLIT: begin
					way_q   <= '0;
					hit_q   <= 1'b0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					way_q <= way_q + WAY_W'(1);
					if (tag_match) begin
						hit_q   <= 1'b1;
						state_q <= ST_UPDATE;
					end else if (last_way) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: begin
					hits_q   <= hits_n;
					misses_q <= misses_n;
					evicts_q <= evicts_n;
					done_q   <= 1'b1;
					state_q  <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers without reset.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					act_q  <= cmd.action;
					addr_q <= cmd.address;
					result_q.outcome         <= OUT_IGNORED;
					result_q.hits_total      <= hits_q;
					result_q.misses_total    <= misses_q;
					result_q.evictions_total <= evicts_q;
				end
			end
			ST_SPLIT: begin
				set_q <= set_n;
				tag_q <= tag_n;
			end
			ST_SCAN: begin
				// The first filled way seeds the victim; a later way replaces
				// it only with a strictly older rank.
				if (way_in_fill && (way_q == '0 || cur_rank > victim_rank_q)) begin
					victim_q      <= way_q;
					victim_rank_q <= cur_rank;
				end
				if (tag_match) begin
					hit_way_q  <= way_q;
					hit_rank_q <= cur_rank;
				end
			end
			ST_UPDATE: begin
				result_q.outcome         <= outcome_n;
				result_q.hits_total      <= hits_n;
				result_q.misses_total    <= misses_n;
				result_q.evictions_total <= evicts_n;
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

### rtl/lru_sac_chk.sv
// Port-level checker for the LRU cache model, bound to the top level.
// Depends on lru_sac_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module lru_sac_chk
	import lru_sac_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input logic    busy,
	input access_t cmd,
	input logic    done,
	input result_t result
);

	// A result is only shown once the access is finished.
	`CHK_IMPLY(a_done_not_busy, clk, arst_n, done, !busy)

	// Every result follows either a fetch transfer or the end of a lookup.
	`CHK_IMPLY(a_done_has_cause, clk, arst_n, done, $past(busy) || $past(start))

	// A data access occupies the block before any result appears.
	`CHK_NEXT(a_access_busy, clk, arst_n, start && !busy && cmd.action != ACT_FETCH, busy && !done)

	// A fetch is answered at once as ignored.
	`CHK_NEXT(a_fetch_done, clk, arst_n, start && !busy && cmd.action == ACT_FETCH, done && !busy && result.outcome == OUT_IGNORED)

endmodule

bind lru_set_associative_cache_sim lru_sac_chk u_lru_sac_chk (.*);

`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the tag-only LRU set-associative cache model.
// Depends on lru_sac_pkg and lru_set_associative_cache_sim; needs no other file.

module testbench;
	import lru_sac_pkg::*;

	// Register index that no register answers to; writes there must change nothing.
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

	// A correct run has roughly 2000 transfers, so this limit leaves a wide margin.
	localparam int CYCLE_LIMIT     = 400000;
	localparam int RAND_PHASES     = 12;
	localparam int ITEMS_PER_PHASE = 150;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    start = 1'b0;
	logic    busy;
	access_t cmd = '0;
	logic    done;
	result_t result;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;

	lru_set_associative_cache_sim dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.cmd      (cmd),
		.done     (done),
		.result   (result),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Our own copy of the cache: tags, recency ages (0 is most recent), fill
	// counts per set, the three running counters and the configuration.
	logic [ADDRESS_W-1:0] tag_mem [2**DEF_MAX_SET_BITS][DEF_MAX_WAYS];
	int                   age     [2**DEF_MAX_SET_BITS][DEF_MAX_WAYS];
	int                   fill_count [2**DEF_MAX_SET_BITS];
	logic [CNT_W-1:0]     hit_cnt, miss_cnt, evict_cnt;
	logic [SET_BITS_W-1:0]   cfg_set_bits;
	logic [BLOCK_BITS_W-1:0] cfg_block_bits;
	logic [WAYS_W-1:0]       cfg_ways;

	// Results still owed by the block, oldest first.
	result_t expected_results[$];
	result_t want_res;
	int      mismatches = 0;
	int      cycle_count = 0;

	// A few full-width addresses per phase, reused so that large tags hit.
	logic [ADDRESS_W-1:0] hot_addr [16];

	typedef struct {
		bit                    is_cfg;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_DATA_W-1:0] val;
		action_e               act;
		logic [ADDRESS_W-1:0]  addr;
		bit                    typed;
		result_t               want;
	} stim_row_t;

	stim_row_t dir_rows[$];

	function automatic stim_row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		stim_row_t row;
		row = '{act: ACT_LOAD, default: '0};
		row.is_cfg = 1'b1;
		row.idx = idx;
		row.val = val;
		return row;
	endfunction

	function automatic stim_row_t acc_row(action_e act, logic [ADDRESS_W-1:0] addr);
		stim_row_t row;
		row = '{act: ACT_LOAD, default: '0};
		row.act = act;
		row.addr = addr;
		return row;
	endfunction

	// Access row whose result is obvious from the rules and is typed in directly.
	function automatic stim_row_t chk_row(action_e act, logic [ADDRESS_W-1:0] addr,
			outcome_e oc, int h, int m, int e);
		stim_row_t row;
		row = acc_row(act, addr);
		row.typed = 1'b1;
		row.want.outcome = oc;
		row.want.hits_total = h;
		row.want.misses_total = m;
		row.want.evictions_total = e;
		return row;
	endfunction

	function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] c, int unsigned d);
		return (c > {CNT_W{1'b1}} - d) ? {CNT_W{1'b1}} : c + d;
	endfunction

	// Set index bits above the supported maximum behave as the maximum.
	function automatic int eff_set_bits();
		return (cfg_set_bits > DEF_MAX_SET_BITS) ? DEF_MAX_SET_BITS : int'(cfg_set_bits);
	endfunction

	// Applies one access to the cache copy and returns the result it should produce.
	function automatic result_t predict_access(access_t acc);
		result_t res;
		int sb, set_no, filled, ways_lim, hit_way, victim, old_age, w;
		logic [ADDRESS_W-1:0] line_no, tag;
		res = '0;
		if (action_e'(acc.action) != ACT_FETCH) begin
			sb = eff_set_bits();
			line_no = acc.address >> cfg_block_bits;
			set_no = int'(line_no & ((64'd1 << sb) - 64'd1));
			tag = line_no >> sb;
			filled = fill_count[set_no];
			ways_lim = (cfg_ways == 0) ? 1 :
				((cfg_ways > DEF_MAX_WAYS) ? DEF_MAX_WAYS : int'(cfg_ways));
			hit_way = -1;
			for (w = 0; w < filled; w++)
				if (hit_way < 0 && tag_mem[set_no][w] == tag)
					hit_way = w;
			if (hit_way >= 0) begin
				// Lines younger than the hit line age by one; the hit line becomes newest.
				old_age = age[set_no][hit_way];
				for (w = 0; w < filled; w++)
					if (age[set_no][w] < old_age)
						age[set_no][w]++;
				age[set_no][hit_way] = 0;
				res.outcome = OUT_HIT;
			end else if (filled < ways_lim) begin
				for (w = 0; w < filled; w++)
					age[set_no][w]++;
				tag_mem[set_no][filled] = tag;
				age[set_no][filled] = 0;
				fill_count[set_no] = filled + 1;
				res.outcome = OUT_MISS;
			end else begin
				// The set is full for the current way limit (possibly over it after the
				// limit was lowered): the oldest filled line is replaced in place.
				victim = 0;
				for (w = 0; w < filled; w++)
					if (age[set_no][w] > age[set_no][victim])
						victim = w;
				for (w = 0; w < filled; w++)
					age[set_no][w]++;
				tag_mem[set_no][victim] = tag;
				age[set_no][victim] = 0;
				res.outcome = OUT_EVICT;
			end
			if (res.outcome == OUT_HIT) begin
				hit_cnt = sat_inc(hit_cnt, (action_e'(acc.action) == ACT_MODIFY) ? 2 : 1);
			end else begin
				// A modify that misses still counts the hit of its store half.
				miss_cnt = sat_inc(miss_cnt, 1);
				if (action_e'(acc.action) == ACT_MODIFY)
					hit_cnt = sat_inc(hit_cnt, 1);
				if (res.outcome == OUT_EVICT)
					evict_cnt = sat_inc(evict_cnt, 1);
			end
		end
		res.hits_total = hit_cnt;
		res.misses_total = miss_cnt;
		res.evictions_total = evict_cnt;
		return res;
	endfunction

	// Mostly addresses that land in a few sets with a few tags, so that hits and
	// evictions are frequent; the rest are reused wide addresses and pure noise.
	function automatic logic [ADDRESS_W-1:0] pick_address();
		int sb, pick;
		logic [ADDRESS_W-1:0] line_no, offs_mask;
		sb = eff_set_bits();
		offs_mask = (64'd1 << cfg_block_bits) - 64'd1;
		pick = $urandom_range(0, 99);
		if (pick < 15)
			return {$urandom, $urandom};
		if (pick < 45)
			return hot_addr[$urandom_range(0, 15)] ^ ({$urandom, $urandom} & offs_mask);
		line_no = (64'($urandom_range(0, cfg_ways + 3)) << sb) |
			64'($urandom_range(0, 3) & ((1 << sb) - 1));
		return (line_no << cfg_block_bits) | ({$urandom, $urandom} & offs_mask);
	endfunction

	// Stops offering accesses and waits until every owed result has been seen.
	task automatic settle();
		@(negedge clk);
		start <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		@(posedge clk);
	endtask

	// Registers are only written while the block is idle.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		settle();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_SET_BITS:   cfg_set_bits = val[SET_BITS_W-1:0];
			CFG_BLOCK_BITS: cfg_block_bits = val[BLOCK_BITS_W-1:0];
			CFG_WAYS:       cfg_ways = val[WAYS_W-1:0];
			default: ;
		endcase
	endtask

	// Offers one access and holds it until the transfer happens. The expectation
	// is worked out at the transfer edge, so it is queued in transfer order.
	task automatic send_access(action_e act, logic [ADDRESS_W-1:0] addr, bit typed,
			result_t typed_res);
		access_t acc;
		result_t res;
		acc.action = act;
		acc.address = addr;
		@(negedge clk);
		start <= 1'b1;
		cmd <= acc;
		do
			@(posedge clk);
		while (busy);
		res = predict_access(acc);
		expected_results.push_back(typed ? typed_res : res);
	endtask

	task automatic idle_burst(int n);
		@(negedge clk);
		start <= 1'b0;
		repeat (n - 1)
			@(negedge clk);
	endtask

	// Result side: every cycle with done high is a transfer that cannot be held
	// off, and it must match the oldest expectation field by field.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_results.size() == 0) begin
				$error("result transfer with no access pending: outcome %0d", result.outcome);
				mismatches++;
			end else begin
				want_res = expected_results.pop_front();
				if (result.outcome !== want_res.outcome) begin
					$error("outcome: expected %0d, got %0d", want_res.outcome, result.outcome);
					mismatches++;
				end
				if (result.hits_total !== want_res.hits_total) begin
					$error("hits_total: expected %0d, got %0d",
						want_res.hits_total, result.hits_total);
					mismatches++;
				end
				if (result.misses_total !== want_res.misses_total) begin
					$error("misses_total: expected %0d, got %0d",
						want_res.misses_total, result.misses_total);
					mismatches++;
				end
				if (result.evictions_total !== want_res.evictions_total) begin
					$error("evictions_total: expected %0d, got %0d",
						want_res.evictions_total, result.evictions_total);
					mismatches++;
				end
			end
		end
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin : stimulus
		int phase, counted, idle_pct;
		logic [CFG_DATA_W-1:0] sb_val, bb_val, ways_val;
		action_e act;

		// The cache copy starts empty with the reset geometry: one set, no offset
		// bits, one way.
		foreach (fill_count[j])
			fill_count[j] = 0;
		hit_cnt = '0;
		miss_cnt = '0;
		evict_cnt = '0;
		cfg_set_bits = '0;
		cfg_block_bits = '0;
		cfg_ways = WAYS_W'(1);

		// Directed part. The first rows run on the reset geometry with a single
		// way, where every outcome can be worked out by hand: an ignored fetch,
		// a cold miss, a hit, an eviction, a modify hit counting twice and a
		// modify miss counting a miss and a hit.
		dir_rows.push_back(chk_row(ACT_FETCH,  64'h0, OUT_IGNORED, 0, 0, 0));
		dir_rows.push_back(chk_row(ACT_LOAD,   64'h0, OUT_MISS, 0, 1, 0));
		dir_rows.push_back(chk_row(ACT_LOAD,   64'h0, OUT_HIT, 1, 1, 0));
		dir_rows.push_back(chk_row(ACT_STORE,  64'hFFFF_FFFF_FFFF_FFFF, OUT_EVICT, 1, 2, 1));
		dir_rows.push_back(chk_row(ACT_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF, OUT_HIT, 3, 2, 1));
		dir_rows.push_back(chk_row(ACT_MODIFY, 64'h0, OUT_EVICT, 4, 3, 2));
		dir_rows.push_back(chk_row(ACT_FETCH,  64'hFFFF_FFFF_FFFF_FFFF, OUT_IGNORED, 4, 3, 2));
		// Out-of-range settings: set bits above the maximum, the widest offset
		// and a way count above the maximum.
		dir_rows.push_back(cfg_row(CFG_SET_BITS, 5'd7));
		dir_rows.push_back(cfg_row(CFG_BLOCK_BITS, 5'd31));
		dir_rows.push_back(cfg_row(CFG_WAYS, 5'd15));
		dir_rows.push_back(acc_row(ACT_LOAD,   64'hFFFF_FFFF_FFFF_FFFF));
		dir_rows.push_back(acc_row(ACT_STORE,  64'h8000_0000_0000_0000));
		dir_rows.push_back(acc_row(ACT_MODIFY, 64'h0000_0000_7FFF_FFFF));
		dir_rows.push_back(acc_row(ACT_LOAD,   64'h5555_5555_5555_5555));
		dir_rows.push_back(acc_row(ACT_LOAD,   64'hAAAA_AAAA_AAAA_AAAA));
		dir_rows.push_back(acc_row(ACT_LOAD,   64'hFFFF_FFFF_FFFF_FFFF));
		// A way count of zero acts as one, which leaves set 0 over its limit: the
		// next miss there replaces a line and the fill stays.
		dir_rows.push_back(cfg_row(CFG_WAYS, 5'd0));
		dir_rows.push_back(acc_row(ACT_MODIFY, 64'hC000_0000_0000_0000));
		dir_rows.push_back(cfg_row(CFG_UNUSED_IDX, 5'd31));
		// Geometry changed with lines in place: the old lines stay where they are.
		dir_rows.push_back(cfg_row(CFG_SET_BITS, 5'd0));
		dir_rows.push_back(cfg_row(CFG_BLOCK_BITS, 5'd0));
		dir_rows.push_back(cfg_row(CFG_WAYS, 5'd8));
		dir_rows.push_back(acc_row(ACT_LOAD,   64'h0));
		dir_rows.push_back(acc_row(ACT_FETCH,  64'h1234));
		dir_rows.push_back(acc_row(ACT_STORE,  64'h1));
		dir_rows.push_back(acc_row(ACT_LOAD,   64'h2));
		dir_rows.push_back(acc_row(ACT_MODIFY, 64'h3));
		dir_rows.push_back(acc_row(ACT_LOAD,   64'h4));
		dir_rows.push_back(acc_row(ACT_STORE,  64'h5));
		dir_rows.push_back(acc_row(ACT_LOAD,   64'h6));
		dir_rows.push_back(acc_row(ACT_LOAD,   64'h1));

		repeat (11)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[j]) begin
			if (dir_rows[j].is_cfg)
				write_reg(dir_rows[j].idx, dir_rows[j].val);
			else
				send_access(dir_rows[j].act, dir_rows[j].addr, dir_rows[j].typed,
					dir_rows[j].want);
		end

		// Random part, in phases. Each phase drains the block, sets a new geometry
		// (the first three are the extremes) and then streams accesses. Fetches
		// are mixed in but do not count toward the phase length.
		for (phase = 0; phase < RAND_PHASES; phase++) begin
			if (phase == 0) begin
				sb_val = CFG_DATA_W'(DEF_MAX_SET_BITS);
				bb_val = '0;
				ways_val = CFG_DATA_W'(DEF_MAX_WAYS);
			end else if (phase == 1) begin
				sb_val = 5'd7;
				bb_val = 5'd31;
				ways_val = 5'd15;
			end else if (phase == 2) begin
				sb_val = '0;
				bb_val = 5'd16;
				ways_val = '0;
			end else begin
				sb_val = CFG_DATA_W'($urandom_range(0, 7));
				bb_val = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom_range(0, 31)) :
					CFG_DATA_W'($urandom_range(0, 6));
				ways_val = CFG_DATA_W'($urandom_range(0, 15));
			end
			write_reg(CFG_SET_BITS, sb_val);
			write_reg(CFG_BLOCK_BITS, bb_val);
			write_reg(CFG_WAYS, ways_val);
			foreach (hot_addr[j])
				hot_addr[j] = {$urandom, $urandom};

			// Some phases run with no gaps at all, the last one among them.
			idle_pct = (phase == RAND_PHASES - 1 || phase % 3 == 1) ? 0 : 30;
			counted = 0;
			while (counted < ITEMS_PER_PHASE) begin
				if ($urandom_range(0, 99) < idle_pct)
					idle_burst($urandom_range(1, 6));
				act = ($urandom_range(0, 9) == 0) ? ACT_FETCH : action_e'($urandom_range(0, 2));
				send_access(act, pick_address(), 1'b0, '0);
				if (act != ACT_FETCH)
					counted++;
			end
		end

		// Drain, then watch a little longer for stray result strobes.
		settle();
		repeat (DEF_MAX_WAYS + 8)
			@(posedge clk);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

### lru_set_associative_cache_sim.f
+incdir+rtl
rtl/lru_sac_pkg.sv
rtl/lru_set_associative_cache_sim.sv
rtl/lru_sac_chk.sv
tb/sv/testbench.sv
